### sv/irtx_pkg.sv
// Shared types, constants and helper functions for the IR carrier burst transmitter.
// No dependencies; every other file of the block imports this package.
package irtx_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int SEG_LEN_W   = 24;
  localparam int CARRIER_W   = 20;
  localparam int DUTY_W      = 7;
  localparam int TIME_W      = 20;
  localparam int CFG_W       = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int FIT_W       = 21;

  localparam logic [CFG_IDX_W-1:0] REG_CARRIER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT  = 2'd2;

  localparam logic [CARRIER_W-1:0] RST_CARRIER = 20'd38000;
  localparam logic [DUTY_W-1:0]    RST_DUTY    = 7'd50;
  localparam logic [TIME_W-1:0]    RST_HIGH    = 20'd13;
  localparam logic [TIME_W-1:0]    RST_LOW     = 20'd13;

  // The quotient register holds 1000000 for the period division and later the
  // product period * duty.
  localparam int DIV_W     = 27;
  localparam int DIV_STEPS = DIV_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_W-1:0] US_PER_S = DIV_W'(1000000);

  // floor(x / 100) equals (x * RECIP_100) >> RECIP_SH for every x below 2**30.
  localparam int RECIP_W  = 26;
  localparam int RECIP_SH = 32;
  localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949673;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BUSY      = 2'd1,
    STAT_SPACE_END = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_DIV_PERIOD,
    T_MUL,
    T_SCALE,
    T_FINISH
  } tstate_t;

  typedef logic [LENGTH_BITS-1:0] seg_len_t;

  typedef struct packed {
    cmd_t     cmd;
    seg_len_t length;
    logic     ends;
  } seg_cmd_t;

  typedef struct packed {
    logic              carrier_nz;
    logic              invert;
    logic [TIME_W-1:0] high_time;
    logic [TIME_W-1:0] low_time;
  } timing_t;

  // A duty and a frequency fit when both carrier halves last more than one microsecond.
  function automatic logic timing_fits(logic [CARRIER_W-1:0] f, logic [DUTY_W-1:0] d);
    logic [DUTY_W-1:0] rest;
    logic [FIT_W-1:0]  on_t;
    logic [FIT_W-1:0]  off_t;
    rest  = DUTY_W'(100) - d;
    on_t  = FIT_W'(d) * FIT_W'(10000);
    off_t = FIT_W'(rest) * FIT_W'(10000);
    return (d <= DUTY_W'(100)) && (on_t > FIT_W'(f)) && (off_t > FIT_W'(f));
  endfunction

endpackage

### sv/irtx_if.sv
// Valid/ready channel interfaces for segment commands and waveform results.
// Depends on irtx_pkg for field widths and the status type.
interface irtx_in_if;
  import irtx_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [SEG_LEN_W-1:0] seg_length_us;
  logic                 seg_ends_burst;
  modport source(output valid, cmd, seg_length_us, seg_ends_burst, input ready);
  modport sink(input valid, cmd, seg_length_us, seg_ends_burst, output ready);
endinterface

interface irtx_out_if;
  import irtx_pkg::*;
  logic    valid;
  logic    ready;
  logic    carrier_active;
  logic    pin_level;
  logic    busy_res;
  status_t status;
  modport source(output valid, carrier_active, pin_level, busy_res, status, input ready);
  modport sink(input valid, carrier_active, pin_level, busy_res, status, output ready);
endinterface

### sv/irtx_front.sv
// Front end: takes input transactions and turns them into queued segment commands.
// Depends on irtx_pkg and irtx_in_if.
module irtx_front (
  irtx_in_if.sink             in_ch,
  input  logic                hold,
  input  logic                fifo_full,
  output logic                push,
  output irtx_pkg::seg_cmd_t  push_data
);
  import irtx_pkg::*;

  assign in_ch.ready = !fifo_full && !hold;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    push_data.cmd    = in_ch.cmd ? CMD_LOAD : CMD_TICK;
    // Only the low LENGTH_BITS of the length take part in timing.
    push_data.length = LENGTH_BITS'(in_ch.seg_length_us);
    push_data.ends   = in_ch.seg_ends_burst;
  end

endmodule

### sv/irtx_fifo.sv
// Short command queue between the front end and the waveform engine.
// Depends on irtx_pkg for the command type and depth.
module irtx_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  irtx_pkg::seg_cmd_t push_data,
  output logic               full,
  input  logic               pop,
  output irtx_pkg::seg_cmd_t pop_data,
  output logic               empty
);
  import irtx_pkg::*;

  seg_cmd_t              mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == FIFO_CNT_W'(FIFO_DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/irtx_timing.sv
// Config registers and carrier timing (uses irtx_pkg): a serial divider gets the period
// and a reciprocal multiply the high part when an accepted carrier or duty write leaves a nonzero carrier.
module irtx_timing (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [irtx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irtx_pkg::CFG_W-1:0]     cfg_data,
  output irtx_pkg::timing_t             timing,
  output logic                          busy
);
  import irtx_pkg::*;

  logic [CARRIER_W-1:0] carrier_r, carrier_nxt;
  logic [DUTY_W-1:0]    duty_r, duty_nxt;
  logic                 invert_r, invert_nxt;
  logic [TIME_W-1:0]    high_r, high_nxt;
  logic [TIME_W-1:0]    low_r, low_nxt;
  tstate_t              state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [TIME_W-1:0]    rem_r, rem_nxt;
  logic [TIME_W-1:0]    dvs_r, dvs_nxt;
  logic [TIME_W-1:0]    per_w_r, per_w_nxt;
  logic [DUTY_W-1:0]    duty_w_r, duty_w_nxt;

  logic [TIME_W:0]      rem_sh;
  logic                 ge;
  logic [TIME_W-1:0]    rem_step;
  logic [DIV_W-1:0]     quo_step;
  logic [DIV_W-1:0]     prod;
  logic [DIV_W+RECIP_W-1:0] scaled;
  logic [CARRIER_W-1:0] wr_f;
  logic [DUTY_W-1:0]    wr_d;

  // One restoring division step per cycle.
  always_comb begin
    rem_sh   = {rem_r, quo_r[DIV_W-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    rem_step = ge ? TIME_W'(rem_sh - {1'b0, dvs_r}) : TIME_W'(rem_sh);
    quo_step = {quo_r[DIV_W-2:0], ge};
    prod     = DIV_W'(per_w_r) * DIV_W'(duty_w_r);
    scaled   = (DIV_W+RECIP_W)'(quo_r) * (DIV_W+RECIP_W)'(RECIP_100);
    wr_f     = CARRIER_W'(cfg_data);
    wr_d     = DUTY_W'(cfg_data);
  end

  always_comb begin
    carrier_nxt = carrier_r;
    duty_nxt    = duty_r;
    invert_nxt  = invert_r;
    high_nxt    = high_r;
    low_nxt     = low_r;
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    dvs_nxt     = dvs_r;
    per_w_nxt   = per_w_r;
    duty_w_nxt  = duty_w_r;

    case (state_r)
      T_IDLE: begin
      end
      T_DIV_PERIOD: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          per_w_nxt = quo_step[TIME_W-1:0];
          state_nxt = T_MUL;
        end
      end
      T_MUL: begin
        quo_nxt   = prod;
        state_nxt = T_SCALE;
      end
      T_SCALE: begin
        quo_nxt   = DIV_W'(scaled[RECIP_SH +: TIME_W]);
        state_nxt = T_FINISH;
      end
      T_FINISH: begin
        high_nxt  = quo_r[TIME_W-1:0];
        low_nxt   = per_w_r - quo_r[TIME_W-1:0];
        state_nxt = T_IDLE;
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase

    // A write that changes the timing restarts the calculation with latched operands,
    // so a later write of zero carrier leaves a running calculation intact.
    if (cfg_we) begin
      case (cfg_index)
        REG_CARRIER: begin
          if (wr_f == '0 || timing_fits(wr_f, duty_r)) begin
            carrier_nxt = wr_f;
            if (wr_f != '0) begin
              quo_nxt    = US_PER_S;
              rem_nxt    = '0;
              dvs_nxt    = TIME_W'(wr_f);
              duty_w_nxt = duty_r;
              cnt_nxt    = DIV_CNT_W'(DIV_STEPS - 1);
              state_nxt  = T_DIV_PERIOD;
            end
          end
        end
        REG_DUTY: begin
          if (timing_fits(carrier_r, wr_d)) begin
            duty_nxt = wr_d;
            if (carrier_r != '0) begin
              quo_nxt    = US_PER_S;
              rem_nxt    = '0;
              dvs_nxt    = TIME_W'(carrier_r);
              duty_w_nxt = wr_d;
              cnt_nxt    = DIV_CNT_W'(DIV_STEPS - 1);
              state_nxt  = T_DIV_PERIOD;
            end
          end
        end
        REG_INVERT: begin
          invert_nxt = cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_r <= RST_CARRIER;
      duty_r    <= RST_DUTY;
      invert_r  <= 1'b0;
      high_r    <= RST_HIGH;
      low_r     <= RST_LOW;
      state_r   <= T_IDLE;
      cnt_r     <= '0;
    end else begin
      carrier_r <= carrier_nxt;
      duty_r    <= duty_nxt;
      invert_r  <= invert_nxt;
      high_r    <= high_nxt;
      low_r     <= low_nxt;
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    per_w_r  <= per_w_nxt;
    duty_w_r <= duty_w_nxt;
  end

  assign busy = state_r != T_IDLE;

  always_comb begin
    timing.carrier_nz = carrier_r != '0;
    timing.invert     = invert_r;
    timing.high_time  = high_r;
    timing.low_time   = low_r;
  end

endmodule

### sv/irtx_back.sv
// Waveform engine: times segments and carrier halves and registers each result, one
// command per cycle unless the output stalls. Depends on irtx_pkg and irtx_out_if.
module irtx_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               empty,
  output logic               pop,
  input  irtx_pkg::seg_cmd_t pop_data,
  input  irtx_pkg::timing_t  timing,
  irtx_out_if.source         out_ch
);
  import irtx_pkg::*;

  typedef struct packed {
    logic              modulated;
    logic              emitter;
    logic              in_high;
    logic [TIME_W-1:0] half_left;
  } half_t;

  logic              next_space_r, next_space_nxt;
  seg_len_t          seg_left_r, seg_left_nxt;
  logic [TIME_W-1:0] half_left_r, half_left_nxt;
  logic              in_high_r, in_high_nxt;
  logic              modulated_r, modulated_nxt;
  logic              emitter_r, emitter_nxt;
  status_t           status;
  seg_len_t          seg_dec;
  logic [TIME_W-1:0] half_dec;
  half_t             h;

  logic              out_valid_r;
  logic              carrier_r;
  logic              pin_r;
  logic              busy_r;
  status_t           status_r;

  // Start a carrier half; a half of zero length is skipped, and when both are zero the
  // pulse becomes steady.
  function automatic half_t enter_half(logic high, logic [TIME_W-1:0] hi_t,
                                       logic [TIME_W-1:0] lo_t, logic cur_high,
                                       logic [TIME_W-1:0] cur_half);
    half_t             r;
    logic              hsel;
    logic [TIME_W-1:0] len;
    hsel = high;
    len  = hsel ? hi_t : lo_t;
    if (len == '0) begin
      hsel = !hsel;
      len  = hsel ? hi_t : lo_t;
    end
    if (len == '0) begin
      r.modulated = 1'b0;
      r.emitter   = 1'b1;
      r.in_high   = cur_high;
      r.half_left = cur_half;
    end else begin
      r.modulated = 1'b1;
      r.emitter   = hsel;
      r.in_high   = hsel;
      r.half_left = len;
    end
    return r;
  endfunction

  assign pop = !empty && (!out_valid_r || out_ch.ready);

  always_comb begin
    next_space_nxt = next_space_r;
    seg_left_nxt   = seg_left_r;
    half_left_nxt  = half_left_r;
    in_high_nxt    = in_high_r;
    modulated_nxt  = modulated_r;
    emitter_nxt    = emitter_r;
    status         = STAT_OK;
    seg_dec        = seg_left_r - 1'b1;
    half_dec       = (half_left_r != '0) ? half_left_r - 1'b1 : half_left_r;
    h              = '0;

    case (pop_data.cmd)
      CMD_LOAD: begin
        if (seg_left_r != '0) begin
          status = STAT_BUSY;
        end else if (pop_data.ends && next_space_r) begin
          status = STAT_SPACE_END;
        end else begin
          seg_left_nxt  = pop_data.length;
          modulated_nxt = 1'b0;
          half_left_nxt = '0;
          in_high_nxt   = 1'b0;
          emitter_nxt   = 1'b0;
          if (pop_data.length != '0 && !next_space_r) begin
            if (timing.carrier_nz) begin
              h             = enter_half(1'b1, timing.high_time, timing.low_time,
                                         1'b0, '0);
              modulated_nxt = h.modulated;
              emitter_nxt   = h.emitter;
              in_high_nxt   = h.in_high;
              half_left_nxt = h.half_left;
            end else begin
              emitter_nxt = 1'b1;
            end
          end
          next_space_nxt = pop_data.ends ? 1'b0 : !next_space_r;
        end
      end
      CMD_TICK: begin
        if (seg_left_r != '0) begin
          seg_left_nxt = seg_dec;
          if (seg_dec == '0) begin
            emitter_nxt   = 1'b0;
            modulated_nxt = 1'b0;
            half_left_nxt = '0;
            in_high_nxt   = 1'b0;
          end else if (modulated_r) begin
            half_left_nxt = half_dec;
            if (half_dec == '0) begin
              h             = enter_half(!in_high_r, timing.high_time, timing.low_time,
                                         in_high_r, half_dec);
              modulated_nxt = h.modulated;
              emitter_nxt   = h.emitter;
              in_high_nxt   = h.in_high;
              half_left_nxt = h.half_left;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_space_r <= 1'b0;
      seg_left_r   <= '0;
      half_left_r  <= '0;
      in_high_r    <= 1'b0;
      modulated_r  <= 1'b0;
      emitter_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        next_space_r <= next_space_nxt;
        seg_left_r   <= seg_left_nxt;
        half_left_r  <= half_left_nxt;
        in_high_r    <= in_high_nxt;
        modulated_r  <= modulated_nxt;
        emitter_r    <= emitter_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      carrier_r <= emitter_nxt;
      pin_r     <= emitter_nxt ^ timing.invert;
      busy_r    <= seg_left_nxt != '0;
      status_r  <= status;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.carrier_active = carrier_r;
  assign out_ch.pin_level      = pin_r;
  assign out_ch.busy_res       = busy_r;
  assign out_ch.status         = status_r;

endmodule

### sv/ir_carrier_burst_transmitter_top.sv
// IR carrier burst transmitter: one result per tick or load transaction, one per cycle
// unless a config hold or output back-pressure stalls it. A result passes through the
// queue and the output register before it is offered. The waveform engine's segment and
// carrier timers step once per tick; a two-entry queue lets input and output stall
// independently. Any config write holds the input, and one that starts a calculation
// holds it until the timing is worked out. Reset is synchronous, active low.
module ir_carrier_burst_transmitter_top (
  input  logic                           clk,
  input  logic                           rst_n,
  irtx_in_if.sink                        in_ch,
  irtx_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [irtx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irtx_pkg::CFG_W-1:0]     cfg_data
);
  import irtx_pkg::*;

  seg_cmd_t push_data;
  seg_cmd_t pop_data;
  timing_t  timing;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;
  logic     timing_busy;
  logic     hold;

  assign hold = timing_busy || cfg_we;

  irtx_front u_front (
    .in_ch     (in_ch),
    .hold      (hold),
    .fifo_full (full),
    .push      (push),
    .push_data (push_data)
  );

  irtx_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  irtx_timing u_timing (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .timing    (timing),
    .busy      (timing_busy)
  );

  irtx_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .pop_data (pop_data),
    .timing   (timing),
    .out_ch   (out_ch)
  );

endmodule

### sv/irtx_checker.sv
// Port-level checks on the result channel of the transmitter, bound to the top level.
// Depends on irtx_pkg for the status codes.
module irtx_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       carrier_active,
  input logic       pin_level,
  input logic       busy_res,
  input logic [1:0] status
);
  import irtx_pkg::*;

  // A result that waits keeps its payload.
  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(carrier_active) &&
    $stable(pin_level) && $stable(busy_res) && $stable(status))
    else $error("result transaction changed while stalled");

  // The emitter is only lit while a segment is being timed.
  a_light_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && carrier_active |-> busy_res)
    else $error("emitter on with no segment running");

  // A load rejected for being busy leaves the running segment in place.
  a_busy_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STAT_BUSY |-> busy_res)
    else $error("busy rejection reported while idle");

  // A burst-end rejection only happens between segments.
  a_space_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STAT_SPACE_END |-> !busy_res && !carrier_active)
    else $error("space-end rejection reported while a segment runs");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind ir_carrier_burst_transmitter_top irtx_checker u_irtx_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .carrier_active (out_ch.carrier_active),
  .pin_level      (out_ch.pin_level),
  .busy_res       (out_ch.busy_res),
  .status         (out_ch.status)
);
